// ===== hw/rtl/dcspi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcspi_pkg
// Shared types, constants and word-building helpers for the daisy-chain SPI
// channel-select master.
// ----------------------------------------------------------------------------
package dcspi_pkg;

    localparam int MAX_CHIPS         = 16;
    localparam int CHANNELS_PER_CHIP = 8;
    localparam int CHIP_SHIFT        = $clog2(CHANNELS_PER_CHIP);
    localparam int WORD_W            = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_PHASE_TICKS  = 2'd0;
    localparam logic [1:0] CFG_CHAIN_LENGTH = 2'd1;
    localparam logic [1:0] CFG_ON_CODE      = 2'd2;

    localparam logic [7:0] RST_PHASE_TICKS  = 8'd30;
    localparam logic [4:0] RST_CHAIN_LENGTH = 5'd4;
    localparam logic [1:0] RST_ON_CODE      = 2'd2;

    typedef struct packed {
        logic       start_req;
        logic [7:0] channel;
        logic       data_in;
    } t_in_item;

    typedef struct packed {
        logic              select_n;
        logic              serial_clock;
        logic              data_out;
        logic              busy_res;
        logic              word_valid;
        logic [3:0]        word_position;
        logic [WORD_W-1:0] received_word;
        logic              frame_done;
    } t_out_item;

    typedef struct packed {
        logic [7:0] phase_ticks;
        logic [4:0] chain_length;
        logic [1:0] on_code;
    } t_cfg;

    // chain length clamped to 1..MAX_CHIPS
    function automatic logic [4:0] eff_len(input logic [4:0] len);
        logic [4:0] n;
        n = len;
        if (n == 5'd0) n = 5'd1;
        if (n > 5'(MAX_CHIPS)) n = 5'(MAX_CHIPS);
        return n;
    endfunction

    // word for frame position pos; last chip in the chain goes first
    function automatic logic [WORD_W-1:0] word_for(
        input logic [4:0] len,
        input logic [1:0] code,
        input logic [7:0] channel,
        input logic [3:0] pos
    );
        logic [4:0]        n;
        logic [4:0]        chip;
        logic [3:0]        shamt;
        logic [WORD_W-1:0] w;
        n     = eff_len(len);
        chip  = 5'(channel >> CHIP_SHIFT);
        shamt = {channel[CHIP_SHIFT-1:0], 1'b0};
        w     = '0;
        if (chip < n && {1'b0, pos} == n - 5'd1 - chip) begin
            w = WORD_W'(code) << shamt;
        end
        return w;
    endfunction

endpackage

// ===== hw/rtl/dcspi_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcspi_core
// Bus-timing sequencer: advances the frame state by one tick per transfer and
// forms that tick's pin levels and received-word report.
// ----------------------------------------------------------------------------
module dcspi_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  dcspi_pkg::t_in_item  i_item,
    input  dcspi_pkg::t_cfg      i_cfg,
    output dcspi_pkg::t_out_item o_res
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SETUP = 3'd1;
    localparam logic [2:0] PH_LEAD  = 3'd2;
    localparam logic [2:0] PH_HIGH  = 3'd3;
    localparam logic [2:0] PH_TRAIL = 3'd4;
    localparam logic [2:0] PH_HOLD  = 3'd5;

    logic [2:0]  r_phase,    n_phase;
    logic [7:0]  r_tick,     n_tick;
    logic [3:0]  r_bit,      n_bit;
    logic [3:0]  r_word_idx, n_word_idx;
    logic [7:0]  r_channel,  n_channel;
    logic [15:0] r_tx,       n_tx;
    logic [15:0] r_rx,       n_rx;

    logic [7:0]  ticks;
    logic        shifting;

    always_comb begin
        ticks      = (i_cfg.phase_ticks == 8'd0) ? 8'd1 : i_cfg.phase_ticks;
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_word_idx = r_word_idx;
        n_channel  = r_channel;
        n_tx       = r_tx;
        n_rx       = r_rx;
        o_res      = '0;

        if (r_phase == PH_IDLE) begin
            if (i_item.start_req) begin
                n_channel  = i_item.channel;
                n_word_idx = 4'd0;
                n_bit      = 4'd0;
                n_rx       = '0;
                n_tx       = dcspi_pkg::word_for(i_cfg.chain_length, i_cfg.on_code,
                                                 i_item.channel, 4'd0);
                n_tick     = 8'd0;
                n_phase    = PH_SETUP;
            end
        end else if ({1'b0, r_tick} + 9'd1 < {1'b0, ticks}) begin
            n_tick = r_tick + 8'd1;
        end else begin
            n_tick = 8'd0;
            unique case (r_phase)
                PH_SETUP: begin
                    n_phase = PH_LEAD;
                end
                PH_LEAD: begin
                    n_phase = PH_HIGH;
                end
                PH_HIGH: begin
                    // sample data-in as the clock falls
                    n_rx = {r_rx[14:0], i_item.data_in};
                    if (r_bit == 4'd15) begin
                        o_res.word_valid    = 1'b1;
                        o_res.word_position = r_word_idx;
                        o_res.received_word = n_rx;
                    end
                    n_phase = PH_TRAIL;
                end
                PH_TRAIL: begin
                    if (r_bit == 4'd15) begin
                        if ({1'b0, r_word_idx} + 5'd1 < dcspi_pkg::eff_len(i_cfg.chain_length))
                        begin
                            n_word_idx = r_word_idx + 4'd1;
                            n_bit      = 4'd0;
                            n_tx       = dcspi_pkg::word_for(i_cfg.chain_length,
                                                             i_cfg.on_code, r_channel,
                                                             n_word_idx);
                            n_phase    = PH_LEAD;
                        end else begin
                            n_phase = PH_HOLD;
                        end
                    end else begin
                        n_bit   = r_bit + 4'd1;
                        n_tx    = {r_tx[14:0], 1'b0};
                        n_phase = PH_LEAD;
                    end
                end
                PH_HOLD: begin
                    n_phase          = PH_IDLE;
                    o_res.frame_done = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        shifting           = (n_phase == PH_LEAD) || (n_phase == PH_HIGH) ||
                             (n_phase == PH_TRAIL);
        o_res.select_n     = (n_phase == PH_IDLE);
        o_res.serial_clock = (n_phase == PH_HIGH);
        o_res.data_out     = shifting & n_tx[15];
        o_res.busy_res     = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_bit      <= '0;
            r_word_idx <= '0;
            r_channel  <= '0;
            r_tx       <= '0;
            r_rx       <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bit      <= n_bit;
            r_word_idx <= n_word_idx;
            r_channel  <= n_channel;
            r_tx       <= n_tx;
            r_rx       <= n_rx;
        end
    end

endmodule

// ===== hw/rtl/daisy_chain_spi_channel_select_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daisy_chain_spi_channel_select_master
// SPI mode-0 master that switches one channel on in a daisy chain of driver
// chips and reports every word shifted back from the chain.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                     payload
//  in       input      i_in_valid / o_in_stall       i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_stall     o_out_data (t_out_item)
//  cfg      input      i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
//  each input transfer is one bus tick and yields one output transfer
//  one transfer per cycle: the sequencer state update is a single stage
//  result sits in an output register; input stalls only while that register
//  is full and the output side stalls
//  synchronous active-low reset returns to idle with default register values
// ----------------------------------------------------------------------------
module daisy_chain_spi_channel_select_master (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dcspi_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dcspi_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);

    dcspi_pkg::t_cfg      r_cfg;
    dcspi_pkg::t_out_item r_out_data;
    dcspi_pkg::t_out_item core_res;
    logic                 r_out_valid;
    logic                 in_xfer;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_xfer     = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks  <= dcspi_pkg::RST_PHASE_TICKS;
            r_cfg.chain_length <= dcspi_pkg::RST_CHAIN_LENGTH;
            r_cfg.on_code      <= dcspi_pkg::RST_ON_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dcspi_pkg::CFG_PHASE_TICKS:  r_cfg.phase_ticks  <= i_cfg_data;
                dcspi_pkg::CFG_CHAIN_LENGTH: r_cfg.chain_length <= i_cfg_data[4:0];
                dcspi_pkg::CFG_ON_CODE:      r_cfg.on_code      <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    dcspi_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_xfer),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= core_res;
        end
    end

endmodule

// ===== hw/rtl/dcspi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcspi_checker
// Port-level checks on the output channel of the daisy-chain SPI master.
// ----------------------------------------------------------------------------
module dcspi_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input dcspi_pkg::t_out_item o_out_data
);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // busy is exactly select asserted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.busy_res != o_out_data.select_n)
        else $error("busy and select disagree");

    // clock, data out and received words only inside a frame
    a_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.serial_clock || o_out_data.word_valid ||
                        o_out_data.data_out) |-> !o_out_data.select_n)
        else $error("bus activity with select high");

    // frame end releases select and never coincides with a word report
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_done |->
            o_out_data.select_n && !o_out_data.word_valid)
        else $error("frame done with select low or word report");

endmodule

bind daisy_chain_spi_channel_select_master dcspi_checker u_dcspi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/tb_daisy_chain_spi_channel_select_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_daisy_chain_spi_channel_select_master
// Drives bus ticks into the daisy-chain SPI master with random gaps and output
// stalls, predicts every output tick with a cycle model of the frame
// sequencer and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module tb_daisy_chain_spi_channel_select_master;

    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_PRINTS  = 40;
    localparam int ITEM_TARGET = 1700;

    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_SETUP, SEQ_LEAD, SEQ_HIGH, SEQ_TRAIL, SEQ_HOLD
    } t_seq;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    dcspi_pkg::t_in_item  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    dcspi_pkg::t_out_item out_data;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_idx   = dcspi_pkg::CFG_PHASE_TICKS;
    logic [7:0]           cfg_data  = '0;

    // sequencer model state and register copies
    t_seq        seq_phase       = SEQ_IDLE;
    int          seq_ticks       = 0;
    int          bit_num         = 0;
    int          word_num        = 0;
    logic [7:0]  chan_latched    = '0;
    logic [15:0] tx_word         = '0;
    logic [15:0] rx_word         = '0;
    logic [7:0]  cfg_phase_ticks = dcspi_pkg::RST_PHASE_TICKS;
    logic [4:0]  cfg_chain       = dcspi_pkg::RST_CHAIN_LENGTH;
    logic [1:0]  cfg_code        = dcspi_pkg::RST_ON_CODE;

    dcspi_pkg::t_out_item pending_outputs[$];
    int        errors       = 0;
    int        ticks_sent   = 0;
    int        checked      = 0;
    int        quiet        = 0;
    bit        tx_calm      = 1'b0;
    bit        rx_calm      = 1'b0;
    int        rx_hold_long = 0;

    daisy_chain_spi_channel_select_master uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int chain_chips();
        int n;
        n = int'(cfg_chain);
        if (n < 1) n = 1;
        if (n > dcspi_pkg::MAX_CHIPS) n = dcspi_pkg::MAX_CHIPS;
        return n;
    endfunction

    // word for frame position pos: the last chip of the chain goes out first
    function automatic logic [15:0] chip_word(input int pos);
        int          n;
        int          chip;
        int          sub;
        logic [15:0] w;
        n    = chain_chips();
        chip = int'(chan_latched) / dcspi_pkg::CHANNELS_PER_CHIP;
        sub  = int'(chan_latched) % dcspi_pkg::CHANNELS_PER_CHIP;
        w    = '0;
        if (chip < n && pos == n - 1 - chip) w = 16'(cfg_code) << (2 * sub);
        return w;
    endfunction

    // one bus tick of the frame sequencer; returns the expected output
    function automatic dcspi_pkg::t_out_item advance_sequencer(
        input dcspi_pkg::t_in_item it
    );
        int                   span;
        dcspi_pkg::t_out_item o;
        o    = '0;
        span = (cfg_phase_ticks == 8'd0) ? 1 : int'(cfg_phase_ticks);
        if (seq_phase == SEQ_IDLE) begin
            if (it.start_req) begin
                chan_latched = it.channel;
                word_num     = 0;
                bit_num      = 0;
                rx_word      = '0;
                tx_word      = chip_word(0);
                seq_ticks    = 0;
                seq_phase    = SEQ_SETUP;
            end
        end else if (seq_ticks + 1 < span) begin
            seq_ticks++;
        end else begin
            seq_ticks = 0;
            case (seq_phase)
                SEQ_SETUP: seq_phase = SEQ_LEAD;
                SEQ_LEAD:  seq_phase = SEQ_HIGH;
                SEQ_HIGH: begin
                    // data-in sampled as the clock falls
                    rx_word = {rx_word[14:0], it.data_in};
                    if (bit_num == 15) begin
                        o.word_valid    = 1'b1;
                        o.word_position = 4'(word_num);
                        o.received_word = rx_word;
                    end
                    seq_phase = SEQ_TRAIL;
                end
                SEQ_TRAIL: begin
                    if (bit_num == 15) begin
                        if (word_num + 1 < chain_chips()) begin
                            word_num++;
                            bit_num   = 0;
                            tx_word   = chip_word(word_num);
                            seq_phase = SEQ_LEAD;
                        end else begin
                            seq_phase = SEQ_HOLD;
                        end
                    end else begin
                        bit_num++;
                        tx_word   = tx_word << 1;
                        seq_phase = SEQ_LEAD;
                    end
                end
                SEQ_HOLD: begin
                    seq_phase    = SEQ_IDLE;
                    o.frame_done = 1'b1;
                end
                default: seq_phase = SEQ_IDLE;
            endcase
        end
        o.select_n     = (seq_phase == SEQ_IDLE);
        o.serial_clock = (seq_phase == SEQ_HIGH);
        o.busy_res     = (seq_phase != SEQ_IDLE);
        if (seq_phase == SEQ_LEAD || seq_phase == SEQ_HIGH || seq_phase == SEQ_TRAIL) begin
            o.data_out = tx_word[15];
        end
        return o;
    endfunction

    task automatic report(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) $display("ERROR: %s", msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report($sformatf("output %0d field %s: got %0h, expected %0h",
                             checked, name, got, want));
        end
    endtask

    // one tick transfer on the input side, preceded by a random gap unless tx_calm is set
    task automatic send_tick(input logic start, input logic [7:0] chan);
        int                  gap;
        dcspi_pkg::t_in_item it;
        it.start_req = start;
        it.channel   = chan;
        it.data_in   = 1'($urandom_range(0, 1));
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        pending_outputs.push_back(advance_sequencer(it));
        ticks_sent++;
    endtask

    task automatic noise_tick();
        send_tick(1'b0, 8'($urandom));
    endtask

    // starts are ignored mid-frame, so random start bits are harmless here
    task automatic finish_frame();
        while (seq_phase != SEQ_IDLE) send_tick(1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    task automatic run_frame(input logic [7:0] chan);
        send_tick(1'b1, chan);
        finish_frame();
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_outputs.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        settle();
        cfg_idx  <= idx;
        cfg_data <= val;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dcspi_pkg::CFG_PHASE_TICKS:  cfg_phase_ticks = val;
            dcspi_pkg::CFG_CHAIN_LENGTH: cfg_chain = val[4:0];
            dcspi_pkg::CFG_ON_CODE:      cfg_code = val[1:0];
            default: ;
        endcase
    endtask

    task automatic test_idle_ticks();
        send_tick(1'b0, 8'd0);
        send_tick(1'b0, 8'd255);
        repeat (10) noise_tick();
    endtask

    // frame at reset settings, then registers changed while it runs
    task automatic test_reset_defaults();
        send_tick(1'b1, 8'd1);
        repeat (119) send_tick(1'($urandom_range(0, 1)), 8'($urandom));
        write_reg(dcspi_pkg::CFG_PHASE_TICKS, 8'd1);
        repeat (40) noise_tick();
        write_reg(dcspi_pkg::CFG_ON_CODE, 8'd3);
        // shorter chain ends the frame after the second word
        write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'd2);
        finish_frame();
    endtask

    task automatic test_channel_map();
        write_reg(dcspi_pkg::CFG_PHASE_TICKS, 8'd1);
        write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'd2);
        write_reg(dcspi_pkg::CFG_ON_CODE, 8'd1);
        run_frame(8'd0);
        write_reg(dcspi_pkg::CFG_ON_CODE, 8'd2);
        run_frame(8'd7);
        write_reg(dcspi_pkg::CFG_ON_CODE, 8'd3);
        run_frame(8'd8);
        run_frame(8'd15);
        // chip beyond the chain: all words zero
        run_frame(8'd16);
        write_reg(dcspi_pkg::CFG_ON_CODE, 8'd0);
        run_frame(8'd255);
    endtask

    task automatic test_phase_zero();
        write_reg(dcspi_pkg::CFG_PHASE_TICKS, 8'd0);
        write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'd1);
        write_reg(dcspi_pkg::CFG_ON_CODE, 8'd1);
        run_frame(8'd5);
    endtask

    task automatic test_chain_saturation();
        write_reg(dcspi_pkg::CFG_PHASE_TICKS, 8'd1);
        write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'd0);
        run_frame(8'd0);
        write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'd31);
        write_reg(dcspi_pkg::CFG_ON_CODE, 8'd3);
        tx_calm = 1'b1;
        // chip 14 is second out of a full chain; cut the frame inside its word
        send_tick(1'b1, 8'd119);
        repeat (60) noise_tick();
        write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'd2);
        finish_frame();
        tx_calm = 1'b0;
    endtask

    task automatic test_long_phase();
        write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'd1);
        write_reg(dcspi_pkg::CFG_PHASE_TICKS, 8'd255);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        send_tick(1'b1, 8'd6);
        repeat (300) noise_tick();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        write_reg(dcspi_pkg::CFG_PHASE_TICKS, 8'd2);
        finish_frame();
    endtask

    // receiver holds off while ticks keep coming, so the input side stalls
    task automatic test_backpressure();
        write_reg(dcspi_pkg::CFG_PHASE_TICKS, 8'd1);
        write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'd2);
        tx_calm      = 1'b1;
        rx_hold_long = 300;
        run_frame(8'd10);
        tx_calm = 1'b0;
    endtask

    task automatic test_random();
        int         n;
        logic [7:0] chan;
        while (ticks_sent < ITEM_TARGET) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                write_reg(dcspi_pkg::CFG_PHASE_TICKS, 8'd1);
                write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'($urandom_range(0, 6)));
            end else begin
                write_reg(dcspi_pkg::CFG_PHASE_TICKS, 8'($urandom_range(0, 3)));
                write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'($urandom_range(1, 3)));
            end
            write_reg(dcspi_pkg::CFG_ON_CODE, 8'($urandom_range(0, 3)));
            n = chain_chips();
            if ($urandom_range(0, 3) != 0) chan = 8'($urandom_range(0, n * 8 - 1));
            else chan = 8'($urandom);
            repeat ($urandom_range(0, 4)) noise_tick();
            if ($urandom_range(0, 4) == 0) begin
                // frame broken up by a register write
                send_tick(1'b1, chan);
                repeat ($urandom_range(1, 60)) noise_tick();
                case ($urandom_range(0, 2))
                    0: write_reg(dcspi_pkg::CFG_CHAIN_LENGTH, 8'($urandom_range(0, 3)));
                    1: write_reg(dcspi_pkg::CFG_ON_CODE, 8'($urandom_range(0, 3)));
                    default: write_reg(dcspi_pkg::CFG_PHASE_TICKS,
                                       8'($urandom_range(0, 2)));
                endcase
                finish_frame();
            end else begin
                run_frame(chan);
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial begin : rx_side
        int hold;
        forever begin
            if (rx_hold_long > 0) begin
                hold         = rx_hold_long;
                rx_hold_long = 0;
            end else begin
                hold = rx_calm ? 0 : $urandom_range(0, 10);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
        end
    end

    always @(posedge clk) begin : check_outputs
        dcspi_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_outputs.size() == 0) begin
                report($sformatf("output %0d arrived with nothing expected", checked));
            end else begin
                want = pending_outputs.pop_front();
                compare_field("select_n", out_data.select_n, want.select_n);
                compare_field("serial_clock", out_data.serial_clock, want.serial_clock);
                compare_field("data_out", out_data.data_out, want.data_out);
                compare_field("busy_res", out_data.busy_res, want.busy_res);
                compare_field("word_valid", out_data.word_valid, want.word_valid);
                compare_field("word_position", out_data.word_position, want.word_position);
                compare_field("received_word", out_data.received_word, want.received_word);
                compare_field("frame_done", out_data.frame_done, want.frame_done);
            end
            checked++;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_ticks();
        test_reset_defaults();
        test_channel_map();
        test_phase_zero();
        test_chain_saturation();
        test_long_phase();
        test_backpressure();
        test_random();
        settle();
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
